/* src/gswb_pkg.sv */
// Shared types and constants for the scrolled-window bitplane blitter.
package gswb_pkg;

  localparam int BufRowsDef   = 160;
  localparam int BufWordsDef  = 17;
  localparam int ViewRowsDef  = 128;
  localparam int ViewWordsDef = 15;

  localparam int WordW   = 16;
  localparam int RowW    = 8;
  localparam int ColW    = 5;
  localparam int ShiftW  = 5;
  localparam int OffsetW = 5;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 5;

  localparam logic [CfgIdxW-1:0] CfgShiftX    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffsetY   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCombineOr = 2'd2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_BLIT = 1'b1
  } op_e;

  typedef logic [WordW-1:0] word_t;

endpackage

/* src/gswb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gswb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/gray_scrolled_window_blit.sv */
// Top level of the scrolled-window bitplane blitter.
// Holds a light and a dark 1-bit plane of BUF_ROWS rows by BUF_WORDS 16-bit
// words (bit 15 leftmost). Words are split over two RAMs by word parity, each
// RAM holding the light and dark word of an entry side by side, so the two
// adjacent source words of a blit come out of the same read. A load item
// produces no result. A blit item's RAM read and stage register are taken at
// its accepting edge; the funnel shift and combine settle in the next cycle
// and the result is taken into the output register once the output side is
// not stalled. One item is accepted per cycle as long as the output side is
// not stalled; the rate is set by the single read port of each parity bank.
// Store entries hold no defined value until loaded. Configuration is taken at
// any time (cfg_ready_o is always high) but must only change while the block
// is idle.
module gray_scrolled_window_blit
  import gswb_pkg::*;
#(
  parameter int BUF_ROWS   = BufRowsDef,
  parameter int BUF_WORDS  = BufWordsDef,
  parameter int VIEW_ROWS  = ViewRowsDef,
  parameter int VIEW_WORDS = ViewWordsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [RowW-1:0]    row_index_i,
  input  logic [ColW-1:0]    word_index_i,
  input  word_t              load_light_i,
  input  word_t              load_dark_i,
  input  word_t              dest_light_i,
  input  word_t              dest_dark_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output word_t              out_light_o,
  output word_t              out_dark_o,
  output logic               range_error_o
);

  localparam int EvenWords = (BUF_WORDS + 1) / 2;
  localparam int OddWords  = BUF_WORDS / 2;
  localparam int EvenDepth = BUF_ROWS * EvenWords;
  localparam int OddDepth  = BUF_ROWS * OddWords;
  localparam int EvenAw    = (EvenDepth > 1) ? $clog2(EvenDepth) : 1;
  localparam int OddAw     = (OddDepth > 1) ? $clog2(OddDepth) : 1;
  localparam int SrowW     = RowW + 1;
  localparam int SwordW    = ColW + 1;

  // configuration
  logic [ShiftW-1:0]  shift_x_q;
  logic [OffsetW-1:0] offset_y_q;
  logic               combine_or_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_x_q    <= '0;
      offset_y_q   <= '0;
      combine_or_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgShiftX:    shift_x_q    <= cfg_data_i[ShiftW-1:0];
        CfgOffsetY:   offset_y_q   <= cfg_data_i[OffsetW-1:0];
        CfgCombineOr: combine_or_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage 0: decode and RAM access
  logic              s1_valid_q, s1_valid_d;
  logic              s1_err_q;
  logic [3:0]        s1_shift_q;
  logic              s1_v0_q, s1_v1_q, s1_w0_odd_q;
  word_t             s1_dest_light_q, s1_dest_dark_q;
  logic              out_valid_q, out_valid_d;
  word_t             out_light_q, out_dark_q;
  logic              out_err_q;
  logic              s1_adv;

  logic              accept, is_blit, load_ok, view_err;
  logic              we_even, we_odd, re;
  logic [SrowW-1:0]  srow;
  logic [SwordW-1:0] sword, sword_nx;
  logic              row_ok, v0, v1;
  logic [EvenAw-1:0] even_waddr, even_raddr;
  logic [OddAw-1:0]  odd_waddr, odd_raddr;
  logic [2*WordW-1:0] even_rdata, odd_rdata;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_blit    = (op_e'(opcode_i) == OP_BLIT);

  assign load_ok  = (row_index_i < BUF_ROWS) && (word_index_i < BUF_WORDS);
  assign view_err = (row_index_i >= VIEW_ROWS) || (word_index_i >= VIEW_WORDS);

  assign we_even = accept && !is_blit && load_ok && !word_index_i[0];
  assign we_odd  = accept && !is_blit && load_ok && word_index_i[0];
  assign re      = accept && is_blit && !view_err;

  assign even_waddr = EvenAw'(EvenAw'(row_index_i) * EvenAw'(EvenWords)
                              + EvenAw'(word_index_i[ColW-1:1]));
  assign odd_waddr  = OddAw'(OddAw'(row_index_i) * OddAw'(OddWords)
                             + OddAw'(word_index_i[ColW-1:1]));

  assign srow     = SrowW'(row_index_i) + SrowW'(offset_y_q);
  assign sword    = SwordW'(word_index_i) + SwordW'(shift_x_q[ShiftW-1]);
  assign sword_nx = sword + SwordW'(1);
  assign row_ok   = srow < BUF_ROWS;
  assign v0       = row_ok && (sword < BUF_WORDS);
  assign v1       = row_ok && (sword_nx < BUF_WORDS);

  // even word of the pair is (sword+1)/2 in the even bank, odd is sword/2
  assign even_raddr = EvenAw'(EvenAw'(srow) * EvenAw'(EvenWords)
                              + EvenAw'(sword_nx[SwordW-1:1]));
  assign odd_raddr  = OddAw'(OddAw'(srow) * OddAw'(OddWords)
                             + OddAw'(sword[SwordW-1:1]));

  gswb_ram #(
    .WIDTH (2 * WordW),
    .DEPTH (EvenDepth)
  ) u_even_ram (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (even_waddr),
    .wdata_i ({load_light_i, load_dark_i}),
    .re_i    (re),
    .raddr_i (even_raddr),
    .rdata_o (even_rdata)
  );

  gswb_ram #(
    .WIDTH (2 * WordW),
    .DEPTH (OddDepth)
  ) u_odd_ram (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (odd_waddr),
    .wdata_i ({load_light_i, load_dark_i}),
    .re_i    (re),
    .raddr_i (odd_raddr),
    .rdata_o (odd_rdata)
  );

  always_comb begin
    if (accept && is_blit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_blit) begin
      s1_err_q        <= view_err;
      s1_shift_q      <= shift_x_q[3:0];
      s1_v0_q         <= v0;
      s1_v1_q         <= v1;
      s1_w0_odd_q     <= sword[0];
      s1_dest_light_q <= dest_light_i;
      s1_dest_dark_q  <= dest_dark_i;
    end
  end

  // stage 1: funnel shift and combine
  word_t              w0_light, w0_dark, w1_light, w1_dark;
  logic [2*WordW-1:0] w0_pair, w1_pair;
  logic [2*WordW-1:0] fun_light, fun_dark;
  word_t              res_light, res_dark;

  always_comb begin
    w0_pair  = s1_w0_odd_q ? odd_rdata : even_rdata;
    w1_pair  = s1_w0_odd_q ? even_rdata : odd_rdata;
    w0_light = s1_v0_q ? w0_pair[2*WordW-1:WordW] : '0;
    w0_dark  = s1_v0_q ? w0_pair[WordW-1:0] : '0;
    w1_light = s1_v1_q ? w1_pair[2*WordW-1:WordW] : '0;
    w1_dark  = s1_v1_q ? w1_pair[WordW-1:0] : '0;

    fun_light = {w0_light, w1_light} << s1_shift_q;
    fun_dark  = {w0_dark, w1_dark} << s1_shift_q;
    res_light = fun_light[2*WordW-1:WordW];
    res_dark  = fun_dark[2*WordW-1:WordW];

    if (combine_or_q) begin
      res_light = res_light | s1_dest_light_q;
      res_dark  = res_dark | s1_dest_dark_q;
    end
    if (s1_err_q) begin
      res_light = '0;
      res_dark  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_light_q <= res_light;
      out_dark_q  <= res_dark;
      out_err_q   <= s1_err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_light_o   = out_light_q;
  assign out_dark_o    = out_dark_q;
  assign range_error_o = out_err_q;

endmodule
